// ===== rtl/sit_pkg.sv =====
// Package for the sorted interval table: widths, commands, entry type.
// No dependencies.
package sit_pkg;
   localparam int unsigned TableEntriesDefault = 64;
   localparam int unsigned CoordWidth = 32;
   localparam int unsigned IdWidth = 32;
   localparam int unsigned LenWidth = 24;
   localparam int unsigned StepWidth = 16;
   localparam int unsigned OffsetWidth = 32;
   localparam logic signed [CoordWidth-1:0] CoordMax = 32'sh7FFF_FFFF;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef struct packed {
      logic signed [CoordWidth-1:0] first;
      logic signed [CoordWidth-1:0] last;
      logic [IdWidth-1:0]           id;
      logic [StepWidth-1:0]         step;
   } entry_type;

   // divider control between the sequencer and the divide unit
   typedef struct packed {
      logic        start;
      logic [39:0] dividend;
      logic [StepWidth-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [OffsetWidth-1:0] quotient;
   } div_rsp_type;
endpackage

// ===== rtl/sit_divider.sv =====
// Restoring radix-2 divider, one quotient bit per cycle, saturating at 32 bits.
// Depends on sit_pkg.
module sit_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  sit_pkg::div_req_type req,
   output sit_pkg::div_rsp_type rsp
);
   import sit_pkg::*;

   logic [39:0]          quot_ff, quot_in;
   logic [StepWidth:0]   rem_ff, rem_in;
   logic [StepWidth-1:0] den_ff, den_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [StepWidth:0]   trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[StepWidth-1:0], quot_ff[39]};
      if (req.start) begin
         quot_in = req.dividend;
         rem_in  = '0;
         den_in  = req.divisor;
         cnt_in  = 6'd40;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in  = trial - {1'b0, den_ff};
            quot_in = {quot_ff[38:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[38:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = (quot_ff[39:32] != 8'd0) ? '1 : quot_ff[31:0];
endmodule

// ===== rtl/sit_table_mem.sv =====
// Single-port-write, one-read entry memory with registered read data.
// Depends on sit_pkg.
module sit_table_mem #(
   parameter int unsigned TABLE_ENTRIES = sit_pkg::TableEntriesDefault,
   localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  sit_pkg::entry_type  wr_data,
   input  logic [AW-1:0]       rd_addr,
   output sit_pkg::entry_type  rd_data
);
   import sit_pkg::*;

   entry_type mem [TABLE_ENTRIES];
   entry_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;
endmodule

// ===== rtl/sorted_interval_table.sv =====
// Sorted interval table top level: command sequencer around the entry memory
// and the divider. Depends on sit_pkg, sit_table_mem, sit_divider.
//
// Commands are taken when start is high and busy is low. Busy then stays high
// until the single result is shown for one cycle on rsp_strobe, which the
// receiver cannot stall. Busy falls as the strobe rises, so the next command
// can be taken in the strobe cycle. Clear and the unused command hold busy
// for 1 cycle. An insert walks the table once, reading and testing each stored
// entry, then shifts the entries behind the insert point up one place and
// writes the new entry. When the last entry is cut, the new entry is appended
// after it without a shift. A rejected insert ends after the walk. A lookup
// walks from the search cursor, or from the first entry when the cursor is
// not valid. A hit with a nonzero step then waits for the divider. Table
// depth is TABLE_ENTRIES.
module sorted_interval_table #(
   parameter int unsigned TABLE_ENTRIES = sit_pkg::TableEntriesDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_cmd,
   input  logic [sit_pkg::IdWidth-1:0]          req_object_id,
   input  logic signed [sit_pkg::CoordWidth-1:0] req_start_mm,
   input  logic [sit_pkg::LenWidth-1:0]         req_length_mm,
   input  logic [sit_pkg::StepWidth-1:0]        req_path_step,
   input  logic signed [sit_pkg::CoordWidth-1:0] req_coord_mm,
   input  logic                                 csr_wr_en,
   input  logic                                 csr_wr_data,
   output logic                                 rsp_strobe,
   output logic                                 rsp_accepted,
   output logic                                 rsp_hit,
   output logic [sit_pkg::IdWidth-1:0]          rsp_found_id,
   output logic [sit_pkg::OffsetWidth-1:0]      rsp_sample_offset
);
   import sit_pkg::*;

   localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CW-1:0] Full = CW'(TABLE_ENTRIES);
   localparam logic [1:0] DirNone = 2'd0;
   localparam logic [1:0] DirUp   = 2'd1;
   localparam logic [1:0] DirDown = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE, S_INS_RD, S_INS_CHK, S_SH_RD, S_SH_WR, S_INS_TRUNC, S_INS_PUT,
      S_LK_RD, S_LK_CHK, S_DIV, S_DONE
   } state_type;

   state_type state_ff;
   logic moving_down_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] cursor_ff;
   logic          cursor_valid_ff;
   logic [CW-1:0] idx_ff;
   logic [CW-1:0] pos_ff;
   logic          pos_found_ff;
   logic [1:0]    dir_ff;
   logic [CW-1:0] ovl_ff;
   logic          ovl_found_ff;
   logic          ovl_multi_ff;
   entry_type     ovl_entry_ff;
   entry_type     new_ff;
   logic signed [CoordWidth-1:0] coord_ff;
   logic          res_acc_ff, res_hit_ff, strobe_ff;
   logic [IdWidth-1:0] res_id_ff;
   logic [OffsetWidth-1:0] res_off_ff;

   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   entry_type     mem_wdata, rd;
   div_req_type   dreq;
   div_rsp_type   drsp;

   logic signed [CoordWidth:0] end_wide;
   logic signed [CoordWidth-1:0] end_sat;
   logic signed [CoordWidth:0] distance;

   sit_table_mem #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_mem (
      .clock(clock), .wr_en(mem_we), .wr_addr(mem_waddr), .wr_data(mem_wdata),
      .rd_addr(mem_raddr), .rd_data(rd)
   );

   sit_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   assign end_wide = {req_start_mm[CoordWidth-1], req_start_mm}
                   + $signed({{(CoordWidth+1-LenWidth){1'b0}}, req_length_mm});
   assign end_sat  = (end_wide > $signed({1'b0, CoordMax})) ? CoordMax
                   : end_wide[CoordWidth-1:0];
   assign distance = moving_down_ff
               ? ({rd.last[CoordWidth-1], rd.last} - {coord_ff[CoordWidth-1], coord_ff})
               : ({coord_ff[CoordWidth-1], coord_ff} - {rd.first[CoordWidth-1], rd.first});

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = idx_ff[AW-1:0];
      mem_wdata = new_ff;
      mem_raddr = idx_ff[AW-1:0];
      unique case (state_ff)
         S_SH_RD:     mem_raddr = AW'(idx_ff - CW'(1));
         S_SH_WR: begin
            mem_we = 1'b1;
            mem_wdata = rd;
         end
         S_INS_TRUNC: begin
            mem_we    = 1'b1;
            mem_waddr = ovl_ff[AW-1:0];
            mem_wdata = ovl_entry_ff;
            mem_wdata.last = new_ff.first - 32'sd1;
         end
         S_INS_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff[AW-1:0];
         end
         default: ;
      endcase
      dreq.start    = (state_ff == S_LK_CHK) && (coord_ff >= rd.first)
                      && (coord_ff <= rd.last) && (rd.step != '0);
      // distance fits 32 bits unsigned; times 100 fits 39 bits
      dreq.dividend = {8'd0, distance[31:0]} * 40'd100;
      dreq.divisor  = rd.step;
   end

   always_ff @(posedge clock) begin
      strobe_ff <= 1'b0;
      if (csr_wr_en) begin
         moving_down_ff <= csr_wr_data;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               res_acc_ff <= 1'b0;
               res_hit_ff <= 1'b0;
               res_id_ff  <= '0;
               res_off_ff <= '0;
               new_ff.first <= req_start_mm;
               new_ff.last  <= end_sat;
               new_ff.id    <= req_object_id;
               new_ff.step  <= req_path_step;
               coord_ff     <= req_coord_mm;
               idx_ff       <= '0;
               unique case (cmd_type'(req_cmd))
                  CMD_INSERT: begin
                     cursor_valid_ff <= 1'b0;
                     pos_ff <= count_ff;
                     pos_found_ff <= 1'b0;
                     ovl_found_ff <= 1'b0;
                     ovl_multi_ff <= 1'b0;
                     state_ff <= (count_ff == '0) ? S_INS_PUT : S_INS_RD;
                     if (count_ff == Full) state_ff <= S_INS_RD;
                  end
                  CMD_CLEAR: begin
                     count_ff <= '0;
                     cursor_valid_ff <= 1'b0;
                     res_acc_ff <= 1'b1;
                     state_ff <= S_DONE;
                  end
                  CMD_LOOKUP: begin
                     if (count_ff == '0) begin
                        state_ff <= S_DONE;
                     end else if (!cursor_valid_ff || cursor_ff >= count_ff) begin
                        dir_ff <= DirUp;
                        state_ff <= S_LK_RD;
                     end else begin
                        idx_ff <= cursor_ff;
                        dir_ff <= DirNone;
                        state_ff <= S_LK_RD;
                     end
                  end
                  default: state_ff <= S_DONE;
               endcase
            end
         end
         S_INS_RD: state_ff <= S_INS_CHK;
         S_INS_CHK: begin
            if (!(new_ff.last < rd.first || new_ff.first > rd.last)) begin
               if (ovl_found_ff) ovl_multi_ff <= 1'b1;
               else begin
                  ovl_found_ff <= 1'b1;
                  ovl_ff <= idx_ff;
                  ovl_entry_ff <= rd;
               end
            end
            if (!pos_found_ff && new_ff.last < rd.first) begin
               pos_found_ff <= 1'b1;
               pos_ff <= idx_ff;
            end
            if (idx_ff + CW'(1) < count_ff) begin
               idx_ff <= idx_ff + CW'(1);
               state_ff <= S_INS_RD;
            end else begin
               // decide with this entry's overlap folded in
               idx_ff <= count_ff;
               state_ff <= S_DONE;
               if (count_ff != Full) begin
                  if (!ovl_found_ff && (new_ff.last < rd.first
                      || new_ff.first > rd.last)) begin
                     state_ff <= (pos_found_ff || new_ff.last < rd.first)
                               ? S_SH_RD : S_INS_PUT;
                     if (!pos_found_ff && new_ff.last >= rd.first) pos_ff <= count_ff;
                     res_acc_ff <= 1'b1;
                     if (pos_found_ff || new_ff.last < rd.first) begin
                        if (!pos_found_ff) pos_ff <= idx_ff;
                        if (count_ff == (pos_found_ff ? pos_ff : idx_ff))
                           state_ff <= S_INS_PUT;
                     end
                  end else if (!ovl_found_ff && !ovl_multi_ff
                      && ($signed({rd.first[CoordWidth-1], rd.first}) + 33'sd1
                          < $signed({new_ff.first[CoordWidth-1], new_ff.first}))) begin
                     // only the last entry overlaps: cut it, then append
                     ovl_ff <= idx_ff;
                     ovl_entry_ff <= rd;
                     pos_ff <= count_ff;
                     res_acc_ff <= 1'b1;
                     state_ff <= S_INS_TRUNC;
                  end
               end
            end
         end
         S_SH_RD: state_ff <= S_SH_WR;
         S_SH_WR: begin
            if (idx_ff - CW'(1) == pos_ff) state_ff <= S_INS_PUT;
            else begin
               idx_ff <= idx_ff - CW'(1);
               state_ff <= S_SH_RD;
            end
         end
         S_INS_TRUNC: state_ff <= S_INS_PUT;
         S_INS_PUT: begin
            count_ff <= count_ff + CW'(1);
            res_acc_ff <= 1'b1;
            state_ff <= S_DONE;
         end
         S_LK_RD: state_ff <= S_LK_CHK;
         S_LK_CHK: begin
            if (coord_ff >= rd.first && coord_ff <= rd.last) begin
               cursor_valid_ff <= 1'b1;
               cursor_ff <= idx_ff;
               res_hit_ff <= 1'b1;
               res_id_ff  <= rd.id;
               if (rd.step == '0) begin
                  res_off_ff <= '1;
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_DIV;
               end
            end else if (coord_ff < rd.first) begin
               if (idx_ff != '0 && dir_ff != DirUp) begin
                  dir_ff <= DirDown;
                  idx_ff <= idx_ff - CW'(1);
                  state_ff <= S_LK_RD;
               end else begin
                  cursor_valid_ff <= 1'b0;
                  state_ff <= S_DONE;
               end
            end else if (dir_ff != DirDown && idx_ff + CW'(1) < count_ff) begin
               dir_ff <= DirUp;
               idx_ff <= idx_ff + CW'(1);
               state_ff <= S_LK_RD;
            end else begin
               cursor_valid_ff <= 1'b0;
               state_ff <= S_DONE;
            end
         end
         S_DIV: begin
            if (drsp.done) begin
               res_off_ff <= drsp.quotient;
               state_ff <= S_DONE;
            end
         end
         S_DONE: begin
            strobe_ff <= 1'b1;
            state_ff <= S_IDLE;
         end
         default: state_ff <= S_IDLE;
      endcase
      if (reset) begin
         state_ff <= S_IDLE;
         moving_down_ff <= 1'b0;
         count_ff <= '0;
         cursor_ff <= '0;
         cursor_valid_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_strobe        = strobe_ff;
   assign rsp_accepted      = res_acc_ff;
   assign rsp_hit           = res_hit_ff;
   assign rsp_found_id      = res_id_ff;
   assign rsp_sample_offset = res_off_ff;
endmodule

// ===== rtl/sit_checker.sv =====
// Port-level checks for the sorted interval table, bound to the top level.
// Depends on sorted_interval_table.
module sit_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic        rsp_accepted,
   input logic        rsp_hit,
   input logic [31:0] rsp_found_id,
   input logic [31:0] rsp_sample_offset
);
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("transfer did not raise busy");
   a_strobe_one: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("strobe longer than one cycle");
   a_hit_acc: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_hit && rsp_accepted)) else $error("hit with accepted");
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_hit) |-> (rsp_found_id == 32'd0 && rsp_sample_offset == 32'd0))
      else $error("miss with payload");
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy) else $error("result while busy");
endmodule

bind sorted_interval_table sit_checker u_sit_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_strobe(rsp_strobe), .rsp_accepted(rsp_accepted), .rsp_hit(rsp_hit),
   .rsp_found_id(rsp_found_id), .rsp_sample_offset(rsp_sample_offset)
);

// ===== dv/sorted_interval_table_tb.sv =====
// Self-checking testbench for the sorted interval table top level.
// Depends on sit_pkg and sorted_interval_table; predicts every result in-line.
`timescale 1ns / 100ps

module sorted_interval_table_tb;
   import sit_pkg::*;

   localparam int Depth = 64;
   localparam int IdleLimit = 20000;

   typedef struct {
      cmd_type     cmd;
      logic [31:0] object_id;
      logic signed [31:0] start_mm;
      logic [23:0] length_mm;
      logic [15:0] path_step;
      logic signed [31:0] coord_mm;
   } command_type;

   typedef struct {
      logic        accepted;
      logic        hit;
      logic [31:0] found_id;
      logic [31:0] sample_offset;
   } answer_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [1:0] req_cmd = CMD_NONE;
   logic [31:0] req_object_id = '0;
   logic signed [31:0] req_start_mm = '0;
   logic [23:0] req_length_mm = '0;
   logic [15:0] req_path_step = '0;
   logic signed [31:0] req_coord_mm = '0;
   logic csr_wr_en = 0;
   logic csr_wr_data = 0;
   logic rsp_strobe, rsp_accepted, rsp_hit;
   logic [31:0] rsp_found_id, rsp_sample_offset;

   sorted_interval_table i_dut (
      .clock, .reset, .start, .busy, .req_cmd, .req_object_id, .req_start_mm,
      .req_length_mm, .req_path_step, .req_coord_mm, .csr_wr_en, .csr_wr_data,
      .rsp_strobe, .rsp_accepted, .rsp_hit, .rsp_found_id, .rsp_sample_offset
   );

   // shadow table
   longint tab_first[Depth], tab_last[Depth];
   logic [31:0] tab_id[Depth];
   logic [15:0] tab_step[Depth];
   int  n_entries;
   bit  cursor_ok;
   int  cursor;
   bit  down_mode;

   command_type pending_cmds[$];
   answer_type  expected_answers[$];
   int  error_count = 0;
   int  idle_pct = 0;
   int  idle_cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic bit add_entry(int pos, logic [31:0] id, longint f, longint l,
                                    logic [15:0] st);
      if (n_entries >= Depth || pos > n_entries) return 0;
      for (int k = n_entries; k > pos; k--) begin
         tab_first[k] = tab_first[k-1];
         tab_last[k] = tab_last[k-1];
         tab_id[k] = tab_id[k-1];
         tab_step[k] = tab_step[k-1];
      end
      tab_first[pos] = f;
      tab_last[pos] = l;
      tab_id[pos] = id;
      tab_step[pos] = st;
      n_entries++;
      return 1;
   endfunction

   function automatic bit table_insert(command_type c);
      longint s, e;
      int k, pos;
      s = longint'(c.start_mm);
      e = s + longint'(c.length_mm);
      if (e > 64'sd2147483647) e = 64'sd2147483647;
      cursor_ok = 0;
      for (k = 0; k < n_entries; k++)
         if (!(e < tab_first[k] || s > tab_last[k])) break;
      if (k == n_entries) begin
         for (pos = 0; pos < n_entries; pos++)
            if (e < tab_first[pos]) break;
         return add_entry(pos, c.object_id, s, e, c.path_step);
      end
      if (k + 1 != n_entries) return 0;
      if (!(tab_first[k] + 1 < s)) return 0;
      if (n_entries >= Depth) return 0;
      tab_last[k] = s - 1;
      return add_entry(n_entries, c.object_id, s, e, c.path_step);
   endfunction

   function automatic int table_search(longint x);
      int dir, i;
      dir = 0;
      if (n_entries == 0) return -1;
      if (!cursor_ok || cursor >= n_entries) begin
         i = 0;
         dir = 1;
      end else i = cursor;
      forever begin
         if (x >= tab_first[i] && x <= tab_last[i]) begin
            cursor_ok = 1;
            cursor = i;
            return i;
         end
         if (x < tab_first[i]) begin
            if (i > 0 && dir != 1) begin
               dir = -1;
               i--;
               continue;
            end
         end else if (dir != -1) begin
            dir = 1;
            i++;
            if (i < n_entries) continue;
         end
         cursor_ok = 0;
         return -1;
      end
   endfunction

   function automatic answer_type predict_answer(command_type c);
      answer_type a;
      longint x;
      longint unsigned span, q;
      int i;
      a = '{0, 0, 0, 0};
      case (c.cmd)
         CMD_INSERT: a.accepted = table_insert(c);
         CMD_CLEAR: begin
            n_entries = 0;
            cursor_ok = 0;
            a.accepted = 1;
         end
         CMD_LOOKUP: begin
            x = longint'(c.coord_mm);
            i = table_search(x);
            if (i >= 0) begin
               span = down_mode ? longint'(tab_last[i] - x) : longint'(x - tab_first[i]);
               if (tab_step[i] == 0) q = 64'hFFFF_FFFF;
               else begin
                  q = span * 100 / tab_step[i];
                  if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
               end
               a.hit = 1;
               a.found_id = tab_id[i];
               a.sample_offset = q[31:0];
            end
         end
         default: ;
      endcase
      return a;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 0;
      end else if (!start || !busy) begin
         if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
            command_type c;
            c = pending_cmds.pop_front();
            expected_answers.push_back(predict_answer(c));
            start <= 1;
            req_cmd <= c.cmd;
            req_object_id <= c.object_id;
            req_start_mm <= c.start_mm;
            req_length_mm <= c.length_mm;
            req_path_step <= c.path_step;
            req_coord_mm <= c.coord_mm;
         end else begin
            start <= 0;
         end
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_strobe) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_strobe) begin
            if (expected_answers.size() == 0) begin
               report("result transfer with nothing expected");
            end else begin
               answer_type a;
               a = expected_answers.pop_front();
               if (rsp_accepted !== a.accepted)
                  report($sformatf("accepted %b exp %b", rsp_accepted, a.accepted));
               if (rsp_hit !== a.hit)
                  report($sformatf("hit %b exp %b", rsp_hit, a.hit));
               if (rsp_found_id !== a.found_id)
                  report($sformatf("found_id %h exp %h", rsp_found_id, a.found_id));
               if (rsp_sample_offset !== a.sample_offset)
                  report($sformatf("offset %h exp %h", rsp_sample_offset, a.sample_offset));
            end
         end
         if (idle_cycles > IdleLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   function automatic command_type make_cmd(cmd_type op, logic [31:0] id,
                                            logic signed [31:0] s,
                                            logic [23:0] len, logic [15:0] st,
                                            logic signed [31:0] x);
      command_type c;
      c.cmd = op;
      c.object_id = id;
      c.start_mm = s;
      c.length_mm = len;
      c.path_step = st;
      c.coord_mm = x;
      return c;
   endfunction

   // random command around a moving base so inserts chain and lookups hit
   function automatic command_type random_cmd(ref longint base);
      int r;
      logic signed [31:0] s, x;
      logic [23:0] len;
      r = $urandom_range(99);
      len = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(2000));
      if (r < 40) begin
         case ($urandom_range(5))
            0: s = $urandom;
            1: s = 32'(base + $urandom_range(1, 500));
            2: s = 32'(base - $urandom_range(3000));
            default: s = 32'(base + $urandom_range(3000));
         endcase
         if ($urandom_range(1)) base = longint'(s) + len;
         return make_cmd(CMD_INSERT, $urandom, s, len,
                         $urandom_range(15) == 0 ? 16'd0 : 16'($urandom), 32'($urandom));
      end
      if (r < 96) begin
         x = ($urandom_range(7) == 0) ? 32'($urandom) : 32'(base - $urandom_range(20000));
         return make_cmd(CMD_LOOKUP, $urandom, $urandom, 24'($urandom), 16'($urandom), x);
      end
      if (r < 98)
         return make_cmd(CMD_CLEAR, $urandom, $urandom, 24'($urandom), 16'($urandom),
                         $urandom);
      return make_cmd(CMD_NONE, $urandom, $urandom, 24'($urandom), 16'($urandom), $urandom);
   endfunction

   task automatic drain();
      while (pending_cmds.size() != 0 || expected_answers.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_mode(bit v);
      csr_wr_en <= 1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 0;
      down_mode = v;
   endtask

   initial begin
      longint base;
      n_entries = 0;
      cursor_ok = 0;
      cursor = 0;
      down_mode = 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      write_mode(0);

      // directed: extremes, saturation, truncation of last entry, zero step
      pending_cmds.push_back(make_cmd(CMD_LOOKUP, 0, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(CMD_INSERT, 32'hFFFF_FFFF, 32'sh8000_0000,
                                      24'hFF_FFFF, 16'hFFFF, 0));
      pending_cmds.push_back(make_cmd(CMD_LOOKUP, 0, 0, 0, 0, 32'sh8000_0000));
      pending_cmds.push_back(make_cmd(CMD_LOOKUP, 0, 0, 0, 0, 32'sh80FF_FFFF));
      pending_cmds.push_back(make_cmd(CMD_INSERT, 1, 32'sh7FFF_FF00, 24'hFF_FFFF, 0, 0));
      pending_cmds.push_back(make_cmd(CMD_LOOKUP, 0, 0, 0, 0, 32'sh7FFF_FFFF));
      pending_cmds.push_back(make_cmd(CMD_INSERT, 2, 32'sh7FFF_FFF0, 24'd5, 16'd1, 0));
      pending_cmds.push_back(make_cmd(CMD_LOOKUP, 0, 0, 0, 0, 32'sh7FFF_FFF2));
      pending_cmds.push_back(make_cmd(CMD_LOOKUP, 0, 0, 0, 0, 32'sh7FFF_FF01));
      pending_cmds.push_back(make_cmd(CMD_INSERT, 3, 32'sh7FFF_FF01, 24'd2, 16'd1, 0));
      pending_cmds.push_back(make_cmd(CMD_INSERT, 4, 0, 24'd100, 16'd0, 0));
      pending_cmds.push_back(make_cmd(CMD_LOOKUP, 0, 0, 0, 0, 32'sd50));
      pending_cmds.push_back(make_cmd(CMD_INSERT, 5, 32'sd50, 24'd10, 16'd3, 0));
      pending_cmds.push_back(make_cmd(CMD_NONE, 7, 7, 7, 7, 7));
      pending_cmds.push_back(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0));
      pending_cmds.push_back(make_cmd(CMD_LOOKUP, 0, 0, 0, 0, 32'sd50));
      drain();
      write_mode(1);
      // fill the table to capacity, then overflow
      for (int k = 0; k < Depth + 2; k++)
         pending_cmds.push_back(make_cmd(CMD_INSERT, k, 32'(k * 10), 24'd5, 16'd1, 0));
      pending_cmds.push_back(make_cmd(CMD_INSERT, 99, 32'sd642, 24'd9, 16'd1, 0));
      pending_cmds.push_back(make_cmd(CMD_LOOKUP, 0, 0, 0, 0, 32'sd630));
      pending_cmds.push_back(make_cmd(CMD_LOOKUP, 0, 0, 0, 0, 32'sd3));
      drain();

      // random phases: idle percentages and register settings vary
      base = 0;
      for (int ph = 0; ph < 6; ph++) begin
         idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 58 : 16;
         write_mode(ph[0]);
         pending_cmds.push_back(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0));
         for (int k = 0; k < 225; k++) pending_cmds.push_back(random_cmd(base));
         drain();
      end

      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
